// ===== src/sac_pkg.sv =====
package sac_pkg;

  localparam int MAX_SETS_LOG2 = 8;
  localparam int MAX_WAYS      = 8;

  localparam int NUM_SETS  = 1 << MAX_SETS_LOG2;
  localparam int SET_W     = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int IB_W      = $clog2(MAX_SETS_LOG2 + 1);
  localparam int TAG_W     = 32;
  localparam int AGE_W     = 3;
  localparam int CNT_W     = 32;

  localparam logic [AGE_W-1:0] AGE_TOP = '1;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_WR
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// ===== src/sac_ram.sv =====
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/set_assoc_lru_cache_sim_core.sv =====
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+-------------------------------
// input    | in_command, in_address                       | taken when start && !busy
// result   | out_hits_now, out_missed, out_evicted,       | out_valid high for one cycle
//          | out_total_hits, out_total_misses,            |
//          | out_total_evictions                          |
// config   | cfg_we, cfg_index, cfg_data                  | written when cfg_we is high
//
// An item with a valid command holds busy while the block reads the set row, makes one
// tag compare per way scanned (1 up to ways_in_use) through the shared comparator and
// writes the row back; an item with an unknown command holds busy only for the write-back
// state. The result shows in the first cycle with busy low, which is also the first cycle
// a new item can be taken. Reset (rst_n low at a clock edge) clears the set valid bits,
// counters, sequencer state and result strobe and loads the default configuration; the
// line memory itself needs no clearing pass. The receiver cannot stall results.
module set_assoc_lru_cache_sim_core (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic [31:0]               in_address,

  output logic                      out_valid,
  output logic [1:0]                out_hits_now,
  output logic                      out_missed,
  output logic                      out_evicted,
  output logic [sac_pkg::CNT_W-1:0] out_total_hits,
  output logic [sac_pkg::CNT_W-1:0] out_total_misses,
  output logic [sac_pkg::CNT_W-1:0] out_total_evictions,

  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [4:0]                cfg_data
);

  // Configuration registers.
  logic [3:0] index_bits_r;
  logic [4:0] offset_bits_r;
  logic [3:0] ways_in_use_r;

  // Sequencer and per-item registers.
  sac_pkg::state_t state_r, state_nxt;
  logic [1:0]                    cmd_r, cmd_nxt;
  logic [31:0]                   addr_r, addr_nxt;
  logic [sac_pkg::SET_W-1:0]     set_r, set_nxt;
  logic [sac_pkg::TAG_W-1:0]     tag_r, tag_nxt;
  logic [5:0]                    sh_r, sh_nxt;
  logic [sac_pkg::WAY_CNT_W-1:0] nways_r, nways_nxt;
  logic                          row_ok_r, row_ok_nxt;

  // Scan bookkeeping.
  logic [sac_pkg::WAY_W-1:0]     way_r, way_nxt;
  logic                          hit_r, hit_nxt;
  logic [sac_pkg::WAY_W-1:0]     hit_way_r, hit_way_nxt;
  logic [sac_pkg::AGE_W-1:0]     hit_age_r, hit_age_nxt;
  logic                          inv_found_r, inv_found_nxt;
  logic [sac_pkg::WAY_W-1:0]     inv_way_r, inv_way_nxt;
  logic [sac_pkg::WAY_W-1:0]     vic_way_r, vic_way_nxt;
  logic [sac_pkg::AGE_W-1:0]     vic_age_r, vic_age_nxt;

  // Totals and result registers.
  logic [sac_pkg::CNT_W-1:0] hit_total_r, hit_total_nxt;
  logic [sac_pkg::CNT_W-1:0] miss_total_r, miss_total_nxt;
  logic [sac_pkg::CNT_W-1:0] evict_total_r, evict_total_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_hits_now_r, out_hits_now_nxt;
  logic                      out_missed_r, out_missed_nxt;
  logic                      out_evicted_r, out_evicted_nxt;

  // One valid bit per set row; a row never written reads as all lines invalid, age zero.
  logic set_valid_r [sac_pkg::NUM_SETS];

  // Line memory, one row per set.
  logic                        ram_we;
  logic                        ram_re;
  logic [sac_pkg::ROW_W-1:0]   ram_rdata;
  sac_pkg::row_t               row_rd;
  sac_pkg::row_t               row_eff;
  sac_pkg::row_t               row_wr;

  // Shared barrel shifter: it extracts the set index when the item is taken and the tag
  // in the following cycle.
  logic [31:0] shift_in;
  logic [5:0]  shift_amt;
  logic [31:0] shift_out;

  // Clamped configuration, sampled when an item is taken.
  logic [sac_pkg::IB_W-1:0]      ib_eff;
  logic [sac_pkg::SET_W:0]       set_mask;
  logic [sac_pkg::WAY_CNT_W-1:0] ways_eff;

  // Scan and write-back helpers.
  sac_pkg::line_t                cur_line;
  logic                          cur_hit;
  logic                          last_way;
  logic [sac_pkg::WAY_W-1:0]     touch_way;
  logic [sac_pkg::AGE_W:0]       older_than;
  logic                          is_modify;
  logic                          evict_now;
  logic [1:0]                    hit_add;
  logic [sac_pkg::CNT_W:0]       hit_sum;

  sac_ram #(
    .WIDTH (sac_pkg::ROW_W),
    .DEPTH (sac_pkg::NUM_SETS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_r),
    .wdata (row_wr),
    .re    (ram_re),
    .raddr (set_r),
    .rdata (ram_rdata)
  );

  assign row_rd = sac_pkg::row_t'(ram_rdata);

  always_comb begin
    ib_eff = (index_bits_r > 4'(sac_pkg::MAX_SETS_LOG2)) ?
             sac_pkg::IB_W'(sac_pkg::MAX_SETS_LOG2) : sac_pkg::IB_W'(index_bits_r);
    set_mask = ((sac_pkg::SET_W+1)'(1) << ib_eff) - (sac_pkg::SET_W+1)'(1);
    if (ways_in_use_r == 4'd0) begin
      ways_eff = sac_pkg::WAY_CNT_W'(1);
    end else if (ways_in_use_r > 4'(sac_pkg::MAX_WAYS)) begin
      ways_eff = sac_pkg::WAY_CNT_W'(sac_pkg::MAX_WAYS);
    end else begin
      ways_eff = sac_pkg::WAY_CNT_W'(ways_in_use_r);
    end
  end

  always_comb begin
    if (state_r == sac_pkg::ST_IDLE) begin
      shift_in  = in_address;
      shift_amt = {1'b0, offset_bits_r};
    end else begin
      shift_in  = addr_r;
      shift_amt = sh_r;
    end
    // A shift of 32 or more yields zero, which is what an oversized tag shift must give.
    shift_out = shift_in >> shift_amt;
  end

  // Mask the row by its set valid bit.
  always_comb begin
    for (int j = 0; j < sac_pkg::MAX_WAYS; j++) begin
      row_eff[j].valid = row_rd[j].valid & row_ok_r;
      row_eff[j].tag   = row_rd[j].tag;
      row_eff[j].age   = row_ok_r ? row_rd[j].age : '0;
    end
  end

  assign cur_line = row_eff[way_r];
  assign cur_hit  = cur_line.valid && (cur_line.tag == tag_r);
  assign last_way = ({1'b0, way_r} == (nways_r - sac_pkg::WAY_CNT_W'(1)));

  // Write-back row: the touched way becomes most recent; other valid lines in use age by one,
  // on a hit only those more recent than it, saturating at the top age.
  always_comb begin
    if (hit_r) begin
      touch_way  = hit_way_r;
      older_than = {1'b0, hit_age_r};
    end else if (inv_found_r) begin
      touch_way  = inv_way_r;
      older_than = {1'b0, sac_pkg::AGE_TOP} + 1'b1;
    end else begin
      touch_way  = vic_way_r;
      older_than = {1'b0, sac_pkg::AGE_TOP} + 1'b1;
    end
    for (int j = 0; j < sac_pkg::MAX_WAYS; j++) begin
      row_wr[j] = row_eff[j];
      if (sac_pkg::WAY_W'(j) == touch_way) begin
        row_wr[j].valid = 1'b1;
        row_wr[j].age   = '0;
        if (!hit_r) begin
          row_wr[j].tag = tag_r;
        end
      end else if ((sac_pkg::WAY_CNT_W'(j) < nways_r) && row_eff[j].valid &&
                   ({1'b0, row_eff[j].age} < older_than) &&
                   (row_eff[j].age < sac_pkg::AGE_TOP)) begin
        row_wr[j].age = row_eff[j].age + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    addr_nxt         = addr_r;
    set_nxt          = set_r;
    tag_nxt          = tag_r;
    sh_nxt           = sh_r;
    nways_nxt        = nways_r;
    row_ok_nxt       = row_ok_r;
    way_nxt          = way_r;
    hit_nxt          = hit_r;
    hit_way_nxt      = hit_way_r;
    hit_age_nxt      = hit_age_r;
    inv_found_nxt    = inv_found_r;
    inv_way_nxt      = inv_way_r;
    vic_way_nxt      = vic_way_r;
    vic_age_nxt      = vic_age_r;
    hit_total_nxt    = hit_total_r;
    miss_total_nxt   = miss_total_r;
    evict_total_nxt  = evict_total_r;
    out_valid_nxt    = 1'b0;
    out_hits_now_nxt = out_hits_now_r;
    out_missed_nxt   = out_missed_r;
    out_evicted_nxt  = out_evicted_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    is_modify        = (cmd_r == sac_pkg::CMD_MODIFY);
    evict_now        = !hit_r && !inv_found_r;
    hit_add          = '0;
    hit_sum          = '0;

    case (state_r)
      sac_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          addr_nxt  = in_address;
          set_nxt   = shift_out[sac_pkg::SET_W-1:0] & set_mask[sac_pkg::SET_W-1:0];
          sh_nxt    = 6'(ib_eff) + {1'b0, offset_bits_r};
          nways_nxt = ways_eff;
          // An unknown command makes no access and goes straight to reporting.
          state_nxt = (in_command > sac_pkg::CMD_MODIFY) ? sac_pkg::ST_WR : sac_pkg::ST_RD;
        end
      end

      sac_pkg::ST_RD: begin
        ram_re        = 1'b1;
        row_ok_nxt    = set_valid_r[set_r];
        tag_nxt       = shift_out;
        way_nxt       = '0;
        hit_nxt       = 1'b0;
        inv_found_nxt = 1'b0;
        vic_way_nxt   = '0;
        vic_age_nxt   = '0;
        state_nxt     = sac_pkg::ST_SCAN;
      end

      sac_pkg::ST_SCAN: begin
        if (cur_hit) begin
          hit_nxt     = 1'b1;
          hit_way_nxt = way_r;
          hit_age_nxt = cur_line.age;
          state_nxt   = sac_pkg::ST_WR;
        end else begin
          if (!cur_line.valid && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_way_nxt   = way_r;
          end
          if ((way_r == '0) || (cur_line.age > vic_age_r)) begin
            vic_way_nxt = way_r;
            vic_age_nxt = cur_line.age;
          end
          if (last_way) begin
            state_nxt = sac_pkg::ST_WR;
          end else begin
            way_nxt = way_r + 1'b1;
          end
        end
      end

      sac_pkg::ST_WR: begin
        out_valid_nxt = 1'b1;
        state_nxt     = sac_pkg::ST_IDLE;
        if (cmd_r > sac_pkg::CMD_MODIFY) begin
          out_hits_now_nxt = '0;
          out_missed_nxt   = 1'b0;
          out_evicted_nxt  = 1'b0;
        end else begin
          ram_we = 1'b1;
          // The second access of a modify always hits the line just touched, which is
          // already most recent, so it changes no line state.
          hit_add          = {1'b0, hit_r} + {1'b0, is_modify};
          out_hits_now_nxt = hit_add;
          out_missed_nxt   = !hit_r;
          out_evicted_nxt  = evict_now;
          hit_sum          = {1'b0, hit_total_r} + (sac_pkg::CNT_W+1)'(hit_add);
          hit_total_nxt    = hit_sum[sac_pkg::CNT_W] ? sac_pkg::CNT_TOP :
                             hit_sum[sac_pkg::CNT_W-1:0];
          if (!hit_r && (miss_total_r != sac_pkg::CNT_TOP)) begin
            miss_total_nxt = miss_total_r + 1'b1;
          end
          if (evict_now && (evict_total_r != sac_pkg::CNT_TOP)) begin
            evict_total_nxt = evict_total_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = sac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sac_pkg::ST_IDLE;
      index_bits_r  <= 4'd4;
      offset_bits_r <= 5'd4;
      ways_in_use_r <= 4'd1;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      hit_total_r   <= hit_total_nxt;
      miss_total_r  <= miss_total_nxt;
      evict_total_r <= evict_total_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sac_pkg::REG_INDEX_BITS:  index_bits_r  <= cfg_data[3:0];
          sac_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_data;
          sac_pkg::REG_WAYS_IN_USE: ways_in_use_r <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < sac_pkg::NUM_SETS; s++) begin
        set_valid_r[s] <= 1'b0;
      end
    end else if (ram_we) begin
      set_valid_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    addr_r         <= addr_nxt;
    set_r          <= set_nxt;
    tag_r          <= tag_nxt;
    sh_r           <= sh_nxt;
    nways_r        <= nways_nxt;
    row_ok_r       <= row_ok_nxt;
    way_r          <= way_nxt;
    hit_r          <= hit_nxt;
    hit_way_r      <= hit_way_nxt;
    hit_age_r      <= hit_age_nxt;
    inv_found_r    <= inv_found_nxt;
    inv_way_r      <= inv_way_nxt;
    vic_way_r      <= vic_way_nxt;
    vic_age_r      <= vic_age_nxt;
    out_hits_now_r <= out_hits_now_nxt;
    out_missed_r   <= out_missed_nxt;
    out_evicted_r  <= out_evicted_nxt;
  end

  assign busy                = (state_r != sac_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_hits_now        = out_hits_now_r;
  assign out_missed          = out_missed_r;
  assign out_evicted         = out_evicted_r;
  assign out_total_hits      = hit_total_r;
  assign out_total_misses    = miss_total_r;
  assign out_total_evictions = evict_total_r;

  // A result strobe only ever follows the write-back cycle.
  a_result_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == sac_pkg::ST_WR))
    else $error("result strobe without a write-back cycle");

  // The scan never walks past the ways in use.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sac_pkg::ST_SCAN) |-> ({1'b0, way_r} < nways_r))
    else $error("way scan beyond ways in use");

  // An eviction is always a miss, and a missing item hits at most once.
  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> (out_missed_r && (out_hits_now_r != 2'd2)))
    else $error("eviction reported without a miss");

  // A taken item makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

endmodule
